// File: hdl/vaal_pkg.sv
package vaal_pkg;

    // Fixed point of the angle path: degrees with ANG_FRAC fractional bits.
    localparam int ANG_FRAC = 24;
    // Coordinates are moved up by PRESHIFT bits before the rotations.
    localparam int PRESHIFT = 30;
    localparam int VALUE_W = 17;
    // Accumulated angle, signed; the sum of all table entries stays below 2^31.
    localparam int Z_W = 32;
    // Clamped first-quadrant angle, 0 to 90 degrees, unsigned.
    localparam int ANG_W = 31;
    // Angle after the quadrant fold and rounding offset, signed.
    localparam int R_W = 35;
    localparam int ATAN_N = 32;

    localparam logic signed [Z_W-1:0] Z_90 = 32'sd1509949440;

    // Quadrant offsets with the half-LSB rounding term already folded in.
    localparam logic signed [R_W-1:0] RND_HALF = 35'sd8388608;
    localparam logic signed [R_W-1:0] RND_M180 = -35'sd3011510272;
    localparam logic signed [R_W-1:0] RND_M360 = -35'sd6031409152;

    // atan(2^-i) in degrees, scaled by 2^ANG_FRAC.
    localparam logic signed [Z_W-1:0] ATAN_DEG [ATAN_N] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115,
        32'sd57,        32'sd29,        32'sd14,        32'sd7,
        32'sd4,         32'sd2,         32'sd1,         32'sd0
    };

    // Control that travels alongside the data in every stage.
    typedef struct packed {
        logic vld;
        logic func;
        logic zero;
        logic dx_neg;
        logic dy_neg;
        logic dy_zero;
    } t_flags;

endpackage

// File: hdl/vaal_front.sv
module vaal_front #(
    parameter int CW = 15
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  logic                            i_func,
    input  logic [CW-1:0]                   i_x_start,
    input  logic [CW-1:0]                   i_y_start,
    input  logic [CW-1:0]                   i_x_end,
    input  logic [CW-1:0]                   i_y_end,
    output vaal_pkg::t_flags                o_flags,
    output logic signed [CW+vaal_pkg::PRESHIFT+2:0] o_x,
    output logic signed [CW+vaal_pkg::PRESHIFT+2:0] o_y,
    output logic [2*CW+1:0]                 o_n
);
    localparam int XY_W = CW + vaal_pkg::PRESHIFT + 3;
    localparam int N_W = 2 * CW + 2;

    // Stage 1: coordinate differences.
    logic              r_vld1, r_func1;
    logic signed [CW:0] r_dx, r_dy;
    logic signed [CW:0] n_dx, n_dy;

    assign n_dx = $signed({i_x_end[CW-1], i_x_end}) - $signed({i_x_start[CW-1], i_x_start});
    assign n_dy = $signed({i_y_end[CW-1], i_y_end}) - $signed({i_y_start[CW-1], i_y_start});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
        end
        r_func1 <= i_func;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
    end

    // Stage 2: magnitudes, squares and quadrant flags.
    vaal_pkg::t_flags r_flags2, n_flags2;
    logic [CW-1:0]    r_ax2, r_ay2, n_ax, n_ay;
    logic [CW:0]      abs_dx, abs_dy;
    logic [2*CW-1:0]  r_sqx, r_sqy;

    assign abs_dx = r_dx[CW] ? (CW+1)'(-r_dx) : r_dx;
    assign abs_dy = r_dy[CW] ? (CW+1)'(-r_dy) : r_dy;
    assign n_ax = abs_dx[CW-1:0];
    assign n_ay = abs_dy[CW-1:0];

    always_comb begin
        n_flags2.vld     = r_vld1;
        n_flags2.func    = r_func1;
        n_flags2.zero    = (r_dx == '0) && (r_dy == '0);
        n_flags2.dx_neg  = r_dx[CW];
        n_flags2.dy_neg  = r_dy[CW];
        n_flags2.dy_zero = (r_dy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags2.vld <= 1'b0;
        end else begin
            r_flags2.vld <= n_flags2.vld;
        end
        r_flags2.func    <= n_flags2.func;
        r_flags2.zero    <= n_flags2.zero;
        r_flags2.dx_neg  <= n_flags2.dx_neg;
        r_flags2.dy_neg  <= n_flags2.dy_neg;
        r_flags2.dy_zero <= n_flags2.dy_zero;
        r_ax2 <= n_ax;
        r_ay2 <= n_ay;
        r_sqx <= (2*CW)'(n_ax) * (2*CW)'(n_ax);
        r_sqy <= (2*CW)'(n_ay) * (2*CW)'(n_ay);
    end

    // Stage 3: sum of squares; magnitudes pass on to the rotations.
    vaal_pkg::t_flags r_flags3;
    logic [CW-1:0]    r_ax3, r_ay3;
    logic [N_W-1:0]   r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags3.vld <= 1'b0;
        end else begin
            r_flags3.vld <= r_flags2.vld;
        end
        r_flags3.func    <= r_flags2.func;
        r_flags3.zero    <= r_flags2.zero;
        r_flags3.dx_neg  <= r_flags2.dx_neg;
        r_flags3.dy_neg  <= r_flags2.dy_neg;
        r_flags3.dy_zero <= r_flags2.dy_zero;
        r_ax3 <= r_ax2;
        r_ay3 <= r_ay2;
        r_n   <= N_W'(r_sqx) + N_W'(r_sqy);
    end

    assign o_flags = r_flags3;
    assign o_n     = r_n;
    assign o_x     = $signed(XY_W'({r_ax3, {vaal_pkg::PRESHIFT{1'b0}}}));
    assign o_y     = $signed(XY_W'({r_ay3, {vaal_pkg::PRESHIFT{1'b0}}}));

endmodule

// File: hdl/vaal_stage.sv
module vaal_stage #(
    parameter int CW   = 15,
    parameter int STEP = 0
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  vaal_pkg::t_flags                        i_flags,
    input  logic signed [CW+vaal_pkg::PRESHIFT+2:0] i_x,
    input  logic signed [CW+vaal_pkg::PRESHIFT+2:0] i_y,
    input  logic signed [vaal_pkg::Z_W-1:0]         i_z,
    input  logic [2*CW+1:0]                         i_n,
    input  logic [CW+3:0]                           i_rem,
    input  logic [CW:0]                             i_root,
    output vaal_pkg::t_flags                        o_flags,
    output logic signed [CW+vaal_pkg::PRESHIFT+2:0] o_x,
    output logic signed [CW+vaal_pkg::PRESHIFT+2:0] o_y,
    output logic signed [vaal_pkg::Z_W-1:0]         o_z,
    output logic [2*CW+1:0]                         o_n,
    output logic [CW+3:0]                           o_rem,
    output logic [CW:0]                             o_root
);
    localparam int XY_W = CW + vaal_pkg::PRESHIFT + 3;
    localparam int SQ = CW + 1;
    localparam int REM_W = SQ + 3;
    localparam int N_W = 2 * SQ;

    vaal_pkg::t_flags          r_flags;
    logic signed [XY_W-1:0]    r_x, r_y, n_x, n_y, xs, ys;
    logic signed [vaal_pkg::Z_W-1:0] r_z, n_z;
    logic [N_W-1:0]            r_n;
    logic [REM_W-1:0]          r_rem, n_rem;
    logic [SQ-1:0]             r_root, n_root;

    // One vectoring rotation: drive y toward zero.
    assign xs = i_x >>> STEP;
    assign ys = i_y >>> STEP;

    always_comb begin
        if (!i_y[XY_W-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + vaal_pkg::ATAN_DEG[STEP];
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - vaal_pkg::ATAN_DEG[STEP];
        end
    end

    // One digit of the square root, while digits of n remain.
    generate
        if (STEP < SQ) begin : g_sqrt
            logic [REM_W-1:0] cur, trial;
            assign cur   = {i_rem[REM_W-3:0], i_n[N_W-1-2*STEP -: 2]};
            assign trial = REM_W'({i_root, 2'b01});
            always_comb begin
                if (cur >= trial) begin
                    n_rem  = cur - trial;
                    n_root = {i_root[SQ-2:0], 1'b1};
                end else begin
                    n_rem  = cur;
                    n_root = {i_root[SQ-2:0], 1'b0};
                end
            end
        end else begin : g_hold
            assign n_rem  = i_rem;
            assign n_root = i_root;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.vld <= 1'b0;
        end else begin
            r_flags.vld <= i_flags.vld;
        end
        r_flags.func    <= i_flags.func;
        r_flags.zero    <= i_flags.zero;
        r_flags.dx_neg  <= i_flags.dx_neg;
        r_flags.dy_neg  <= i_flags.dy_neg;
        r_flags.dy_zero <= i_flags.dy_zero;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_n    <= i_n;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_flags = r_flags;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_n     = r_n;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

// File: hdl/vaal_back.sv
module vaal_back #(
    parameter int CW = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vaal_pkg::t_flags                    i_flags,
    input  logic signed [vaal_pkg::Z_W-1:0]     i_z,
    input  logic [CW+3:0]                       i_rem,
    input  logic [CW:0]                         i_root,
    output logic                                o_valid,
    output logic signed [vaal_pkg::VALUE_W-1:0] o_value
);
    localparam int SQ = CW + 1;
    localparam int REM_W = SQ + 3;
    localparam int R_W = vaal_pkg::R_W;

    // Stage A: clamp the angle to 0..90 degrees and round the distance.
    vaal_pkg::t_flags             r_flags;
    logic [vaal_pkg::ANG_W-1:0]   r_a, n_a;
    logic [SQ:0]                  r_dist, n_dist;

    always_comb begin
        if (i_z[vaal_pkg::Z_W-1]) begin
            n_a = '0;
        end else if (i_z > vaal_pkg::Z_90) begin
            n_a = vaal_pkg::ANG_W'(vaal_pkg::Z_90);
        end else begin
            n_a = i_z[vaal_pkg::ANG_W-1:0];
        end
        // The remainder n - root^2 exceeds root exactly when n lies above root + 1/2 squared.
        n_dist = (SQ+1)'(i_root) + (SQ+1)'(i_rem > REM_W'(i_root));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.vld <= 1'b0;
        end else begin
            r_flags.vld <= i_flags.vld;
        end
        r_flags.func    <= i_flags.func;
        r_flags.zero    <= i_flags.zero;
        r_flags.dx_neg  <= i_flags.dx_neg;
        r_flags.dy_neg  <= i_flags.dy_neg;
        r_flags.dy_zero <= i_flags.dy_zero;
        r_a    <= n_a;
        r_dist <= n_dist;
    end

    // Stage B: fold into -360..0, round half up, pick the result.
    logic                  lower, neg_a;
    logic signed [R_W-1:0] ae, cst, sum, shifted;
    logic signed [vaal_pkg::VALUE_W-1:0] n_value;

    assign ae    = $signed(R_W'(r_a));
    assign lower = r_flags.dy_neg || (r_flags.dy_zero && !r_flags.dx_neg);

    always_comb begin
        if (lower) begin
            neg_a = !r_flags.dx_neg;
            cst   = r_flags.dx_neg ? vaal_pkg::RND_M180 : vaal_pkg::RND_HALF;
        end else begin
            neg_a = r_flags.dx_neg;
            cst   = r_flags.dx_neg ? vaal_pkg::RND_M180 : vaal_pkg::RND_M360;
        end
        sum     = (neg_a ? -ae : ae) + cst;
        shifted = sum >>> vaal_pkg::ANG_FRAC;
        if (r_flags.zero) begin
            n_value = '0;
        end else if (r_flags.func) begin
            n_value = $signed(vaal_pkg::VALUE_W'(r_dist));
        end else begin
            n_value = shifted[vaal_pkg::VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_flags.vld;
        end
        o_value <= n_value;
    end

endmodule

// File: hdl/vector_angle_and_length_unit.sv
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             i_func, i_x_start, i_y_start, i_x_end, i_y_end
// result    out        o_valid, one cycle        o_value
//
// One transaction is taken every clock cycle; busy is high only during reset.
// A command passes through three front stages (differences, squares, sum),
// one stage per CORDIC rotation, and two back stages.
// The rotation stages also carry the square root, one result bit per stage while digits of n remain.
// Reset is synchronous and active low and clears only the valid bits.
// The receiver cannot stall; results are presented for exactly one cycle.
module vector_angle_and_length_unit #(
    parameter int COORD_WIDTH  = 15,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [COORD_WIDTH-1:0]              i_x_start,
    input  logic [COORD_WIDTH-1:0]              i_y_start,
    input  logic [COORD_WIDTH-1:0]              i_x_end,
    input  logic [COORD_WIDTH-1:0]              i_y_end,
    output logic                                o_valid,
    output logic signed [vaal_pkg::VALUE_W-1:0] o_value
);
    localparam int CW = COORD_WIDTH;
    localparam int XY_W = CW + vaal_pkg::PRESHIFT + 3;
    localparam int SQ = CW + 1;
    localparam int REM_W = SQ + 3;
    localparam int N_W = 2 * SQ;

    vaal_pkg::t_flags                  flags_c [CORDIC_STEPS+1];
    logic signed [XY_W-1:0]            x_c     [CORDIC_STEPS+1];
    logic signed [XY_W-1:0]            y_c     [CORDIC_STEPS+1];
    logic signed [vaal_pkg::Z_W-1:0]   z_c     [CORDIC_STEPS+1];
    logic [N_W-1:0]                    n_c     [CORDIC_STEPS+1];
    logic [REM_W-1:0]                  rem_c   [CORDIC_STEPS+1];
    logic [SQ-1:0]                     root_c  [CORDIC_STEPS+1];

    assign busy = !i_rst_n;

    vaal_front #(
        .CW(CW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (start && !busy),
        .i_func    (i_func),
        .i_x_start (i_x_start),
        .i_y_start (i_y_start),
        .i_x_end   (i_x_end),
        .i_y_end   (i_y_end),
        .o_flags   (flags_c[0]),
        .o_x       (x_c[0]),
        .o_y       (y_c[0]),
        .o_n       (n_c[0])
    );

    assign z_c[0]    = '0;
    assign rem_c[0]  = '0;
    assign root_c[0] = '0;

    generate
        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
            vaal_stage #(
                .CW   (CW),
                .STEP (i)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_flags (flags_c[i]),
                .i_x     (x_c[i]),
                .i_y     (y_c[i]),
                .i_z     (z_c[i]),
                .i_n     (n_c[i]),
                .i_rem   (rem_c[i]),
                .i_root  (root_c[i]),
                .o_flags (flags_c[i+1]),
                .o_x     (x_c[i+1]),
                .o_y     (y_c[i+1]),
                .o_z     (z_c[i+1]),
                .o_n     (n_c[i+1]),
                .o_rem   (rem_c[i+1]),
                .o_root  (root_c[i+1])
            );
        end
    endgenerate

    vaal_back #(
        .CW(CW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags_c[CORDIC_STEPS]),
        .i_z     (z_c[CORDIC_STEPS]),
        .i_rem   (rem_c[CORDIC_STEPS]),
        .i_root  (root_c[CORDIC_STEPS]),
        .o_valid (o_valid),
        .o_value (o_value)
    );

endmodule

// File: bench/vector_angle_and_length_unit_test.sv
`timescale 1ns / 100ps

module vector_angle_and_length_unit_test;

    localparam int COORD_W   = 15;
    localparam int STEPS     = 24;
    localparam int LATENCY   = STEPS + 5;
    localparam int FRAC      = 24;
    localparam int SHIFT_IN  = 30;
    localparam int VAL_W     = vaal_pkg::VALUE_W;
    localparam int CYCLE_CAP = 200000;
    localparam int COORD_MIN = -(1 << (COORD_W - 1));
    localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;

    typedef enum bit {
        OP_ANGLE    = 1'b0,
        OP_DISTANCE = 1'b1
    } op_e;

    // Arctangent of 2^-i in degrees with FRAC fractional bits.
    localparam longint ARCTAN_DEG [32] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    class angle_length_board;
        logic signed [VAL_W-1:0] pending_values[$];
        int                      mismatches;

        function new();
            mismatches = 0;
        endfunction

        function automatic logic signed [VAL_W-1:0] expected_value(op_e op, int dx, int dy);
            longint ax, ay, x, y, z, xs, ys, r, n, k;
            if (dx == 0 && dy == 0) begin
                return '0;
            end
            if (op == OP_DISTANCE) begin
                n = longint'(dx) * dx + longint'(dy) * dy;
                k = 0;
                for (int b = 17; b >= 0; b--) begin
                    if ((k | (longint'(1) << b)) * (k | (longint'(1) << b)) <= n)
                        k = k | (longint'(1) << b);
                end
                // Round to nearest: the exact root is above k + 1/2.
                if (n > k * k + k)
                    k = k + 1;
                return k[VAL_W-1:0];
            end
            ax = (dx < 0) ? -longint'(dx) : longint'(dx);
            ay = (dy < 0) ? -longint'(dy) : longint'(dy);
            x = ax <<< SHIFT_IN;
            y = ay <<< SHIFT_IN;
            z = 0;
            for (int i = 0; i < STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ARCTAN_DEG[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ARCTAN_DEG[i];
                end
            end
            if (z < 0)
                z = 0;
            if (z > (longint'(90) <<< FRAC))
                z = longint'(90) <<< FRAC;
            // The half plane comes from the signs, so any dy > 0 ends up at or below -180.
            if (dy < 0 || (dy == 0 && dx >= 0))
                r = (dx >= 0) ? -z : z - (longint'(180) <<< FRAC);
            else
                r = (dx >= 0) ? z - (longint'(360) <<< FRAC)
                              : -(longint'(180) <<< FRAC) - z;
            r = (r + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
            return r[VAL_W-1:0];
        endfunction

        function void note_command(op_e op, logic signed [COORD_W-1:0] xs,
                                   logic signed [COORD_W-1:0] ys,
                                   logic signed [COORD_W-1:0] xe,
                                   logic signed [COORD_W-1:0] ye);
            pending_values = {pending_values,
                              expected_value(op, int'(xe) - int'(xs),
                                             int'(ye) - int'(ys))};
        endfunction

        function void check_result(logic signed [VAL_W-1:0] actual);
            logic signed [VAL_W-1:0] want;
            if (pending_values.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0d", $time, actual);
                return;
            end
            want = pending_values.pop_front();
            if (actual !== want) begin
                mismatches++;
                $display("%0t: value mismatch, expected %0d, actual %0d", $time, want, actual);
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_func;
    logic [COORD_W-1:0]        i_x_start;
    logic [COORD_W-1:0]        i_y_start;
    logic [COORD_W-1:0]        i_x_end;
    logic [COORD_W-1:0]        i_y_end;
    logic                      o_valid;
    logic signed [VAL_W-1:0]   o_value;

    angle_length_board board = new();
    int                gap_pct;
    int                cycle_count = 0;

    vector_angle_and_length_unit #(
        .COORD_WIDTH (COORD_W),
        .CORDIC_STEPS(STEPS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_func   (i_func),
        .i_x_start(i_x_start),
        .i_y_start(i_y_start),
        .i_x_end  (i_x_end),
        .i_y_end  (i_y_end),
        .o_valid  (o_valid),
        .o_value  (o_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Transactions are recorded and results checked on the rising edge.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("%0t: timeout", $time);
            $display("Regression FAIL");
            $finish;
        end
        if (i_rst_n && start && !busy)
            board.note_command(op_e'(i_func), i_x_start, i_y_start, i_x_end, i_y_end);
        if (i_rst_n && o_valid)
            board.check_result(o_value);
    end

    task automatic send_command(op_e op, int xs, int ys, int xe, int ye);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_func    <= op;
        i_x_start <= xs[COORD_W-1:0];
        i_y_start <= ys[COORD_W-1:0];
        i_x_end   <= xe[COORD_W-1:0];
        i_y_end   <= ye[COORD_W-1:0];
        do
            @(posedge i_clk);
        while (busy);
    endtask

    task automatic send_both(int xs, int ys, int xe, int ye);
        send_command(OP_ANGLE, xs, ys, xe, ye);
        send_command(OP_DISTANCE, xs, ys, xe, ye);
    endtask

    function automatic int random_coord();
        return int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
    endfunction

    task automatic send_random();
        int xs, ys, xe, ye, dx, dy, pick;
        int corners [4];
        corners = '{COORD_MIN, COORD_MAX, -1, 0};
        xs = random_coord();
        ys = random_coord();
        xe = random_coord();
        ye = random_coord();
        pick = $urandom_range(99);
        if (pick >= 40 && pick < 60) begin
            // Short vectors, where the angle is coarse and the axes are near.
            dx = int'($urandom_range(16)) - 8;
            dy = int'($urandom_range(16)) - 8;
            xe = (xs + dx > COORD_MAX || xs + dx < COORD_MIN) ? xs - dx : xs + dx;
            ye = (ys + dy > COORD_MAX || ys + dy < COORD_MIN) ? ys - dy : ys + dy;
        end else if (pick >= 60 && pick < 70) begin
            if ($urandom_range(1))
                ye = ys;
            else
                xe = xs;
        end else if (pick >= 70 && pick < 80) begin
            xs = corners[$urandom_range(3)];
            ys = corners[$urandom_range(3)];
            xe = corners[$urandom_range(3)];
            ye = corners[$urandom_range(3)];
        end else if (pick >= 80 && pick < 90) begin
            dx = $urandom_range(COORD_MAX);
            xe = (xs >= 0) ? xs - dx : xs + dx;
            ye = (ys >= 0) ? ys - dx : ys + dx;
        end else if (pick >= 90) begin
            xe = xs;
            ye = ys;
        end
        send_command(op_e'($urandom_range(1)), xs, ys, xe, ye);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_func      = 1'b0;
        i_x_start   = '0;
        i_y_start   = '0;
        i_x_end     = '0;
        i_y_end     = '0;
        gap_pct     = 33;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero vectors, the two x half axes and the y axes.
        send_both(5, -7, 5, -7);
        send_both(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_both(0, 0, 100, 0);
        send_both(0, 0, -100, 0);
        send_command(OP_ANGLE, 0, 0, 0, 50);
        send_command(OP_ANGLE, 0, 0, 0, -50);
        // Tiny dy > 0 gives -360, dy < 0 gives 0 for dx > 0; for dx < 0 both give -180.
        send_command(OP_ANGLE, COORD_MIN, 0, COORD_MAX, 1);
        send_command(OP_ANGLE, COORD_MIN, 0, COORD_MAX, -1);
        send_command(OP_ANGLE, COORD_MAX, 0, COORD_MIN, 1);
        send_command(OP_ANGLE, COORD_MAX, 0, COORD_MIN, -1);
        // Longest vectors along both diagonals.
        send_both(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_both(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        send_both(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        send_command(OP_DISTANCE, 0, 0, 3, 4);
        send_command(OP_DISTANCE, 0, 0, 1, 1);

        repeat (433) send_random();
        gap_pct = 86;
        repeat (433) send_random();
        gap_pct = 0;
        repeat (434) send_random();
        @(negedge i_clk);
        start <= 1'b0;

        while (board.pending_values.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_values.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
